>>> design/sensitive_data_class_scanner_assert.svh
// Assertion macros shared by the scanner RTL.
// Included by the front, queue and back modules; no other dependencies.
`ifndef SENSITIVE_DATA_CLASS_SCANNER_ASSERT_SVH
`define SENSITIVE_DATA_CLASS_SCANNER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property holds on every clock edge out of reset.
`define SDCS_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sdcs assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define SDCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdcs assertion failed");
// Consequent holds in the cycle after the antecedent.
`define SDCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdcs assertion failed");
`else
`define SDCS_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define SDCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SDCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/sdcs_pkg.sv
// Package for the sensitive data class scanner: widths, constants, types
// and the digit-run length classifier. No dependencies.
`timescale 1ns / 1ps

package sdcs_pkg;

    // Payload widths
    localparam int ByteW = 8;
    localparam int MaskW = 5;

    // Scan window and byte position counter
    localparam int WindowBytes = 256;
    localparam int PosW        = $clog2(WindowBytes + 1);

    // Run counters
    localparam int DigitW = 5;
    localparam int LetterW = 4;
    localparam logic [DigitW-1:0]  DigitSat  = 5'd20;
    localparam logic [LetterW-1:0] LetterSat = 4'd8;

    // Shape constants
    localparam logic [LetterW-1:0] PanLetters  = 4'd5;
    localparam logic [DigitW-1:0]  PanDigits   = 5'd4;
    localparam logic [LetterW-1:0] IfscLetters = 4'd4;
    localparam logic [DigitW-1:0]  IfscDigits  = 5'd1;
    localparam logic [DigitW-1:0]  AadhaarLen  = 5'd12;
    localparam logic [DigitW-1:0]  CardMinLen  = 5'd13;
    localparam logic [DigitW-1:0]  AcctMinLen  = 5'd9;
    localparam logic [DigitW-1:0]  AcctMaxLen  = 5'd18;

    // ASCII codes
    localparam logic [ByteW-1:0] AsciiZero = 8'h30;
    localparam logic [ByteW-1:0] AsciiNine = 8'h39;
    localparam logic [ByteW-1:0] AsciiUpA  = 8'h41;
    localparam logic [ByteW-1:0] AsciiUpZ  = 8'h5A;

    // Class mask bit positions
    localparam int ClsPan     = 0;
    localparam int ClsAadhaar = 1;
    localparam int ClsIfsc    = 2;
    localparam int ClsAccount = 3;
    localparam int ClsCard    = 4;

    // Front-to-back queue
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef logic [MaskW-1:0] t_mask;

    // One classified byte as handed from front to back
    typedef struct packed {
        logic last;
        logic in_window;
        logic numeral;
        logic capital;
        logic is_zero;
    } t_item;

    // Classes implied by a closed digit run of the given length
    function automatic t_mask run_classes(input logic [DigitW-1:0] run);
        t_mask m;
        m = '0;
        if (run == AadhaarLen) m[ClsAadhaar] = 1'b1;
        if (run >= CardMinLen) m[ClsCard] = 1'b1;
        if (run >= AcctMinLen && run <= AcctMaxLen) m[ClsAccount] = 1'b1;
        return m;
    endfunction

endpackage

>>> design/sdcs_stream_if.sv
// Valid/ready stream interfaces for the scanner's byte input and mask output.
// Depends on sdcs_pkg for payload widths.
`timescale 1ns / 1ps

interface sdcs_in_if;
    import sdcs_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface sdcs_out_if;
    import sdcs_pkg::*;
    logic             valid;
    logic             ready;
    logic [MaskW-1:0] class_bits;

    modport source(output valid, output class_bits, input ready);
    modport sink(input valid, input class_bits, output ready);
endinterface

>>> design/sdcs_front.sv
// Front end: accepts bytes, classifies them and tracks the window position.
// Depends on sdcs_pkg, sdcs_in_if and the assertion header.
`timescale 1ns / 1ps
`include "sensitive_data_class_scanner_assert.svh"

module sdcs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sdcs_in_if.sink         i_in,
    output sdcs_pkg::t_item o_item,
    output logic            o_item_valid,
    input  logic            i_item_ready
);
    import sdcs_pkg::*;

    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    logic            accept;
    logic            in_window;

    assign i_in.ready   = i_item_ready;
    assign o_item_valid = i_in.valid;
    assign accept       = i_in.valid && i_item_ready;
    assign in_window    = r_pos < PosW'(WindowBytes);

    always_comb begin
        o_item.last      = i_in.last_byte;
        o_item.in_window = in_window;
        o_item.numeral   = (i_in.data_byte >= AsciiZero) && (i_in.data_byte <= AsciiNine);
        o_item.capital   = (i_in.data_byte >= AsciiUpA) && (i_in.data_byte <= AsciiUpZ);
        o_item.is_zero   = i_in.data_byte == AsciiZero;
    end

    // Position saturates at the window size and restarts after the last byte
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_in.last_byte) begin
                n_pos = '0;
            end else if (in_window) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    `SDCS_ASSERT_NEXT(a_pos_clears_on_last, i_clk, i_rst_n, accept && i_in.last_byte, r_pos == '0)
    `SDCS_ASSERT_ALWAYS(a_pos_in_range, i_clk, i_rst_n, r_pos <= PosW'(WindowBytes))

endmodule

>>> design/sdcs_queue.sv
// Short FIFO of classified bytes between front and back.
// Depends on sdcs_pkg and the assertion header.
`timescale 1ns / 1ps
`include "sensitive_data_class_scanner_assert.svh"

module sdcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdcs_pkg::t_item i_push_item,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    output sdcs_pkg::t_item o_pop_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready
);
    import sdcs_pkg::*;

    t_item             r_slot [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr;
    logic [QPtrW-1:0]  r_rd_ptr;
    logic [QCntW-1:0]  r_count;
    logic [QPtrW-1:0]  n_wr_ptr;
    logic [QPtrW-1:0]  n_rd_ptr;
    logic [QCntW-1:0]  n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != QCntW'(QDepth);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

    `SDCS_ASSERT_ALWAYS(a_count_bounded, i_clk, i_rst_n, r_count <= QCntW'(QDepth))

endmodule

>>> design/sdcs_back.sv
// Back end: run counters, class detection and the registered mask output.
// Depends on sdcs_pkg, sdcs_out_if and the assertion header.
`timescale 1ns / 1ps
`include "sensitive_data_class_scanner_assert.svh"

module sdcs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdcs_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    sdcs_out_if.source      o_out
);
    import sdcs_pkg::*;

    logic [DigitW-1:0]  r_digit_count;
    logic [LetterW-1:0] r_letter_count;
    logic [LetterW-1:0] r_letters_before;
    t_mask              r_found_mask;
    logic               r_out_valid;
    t_mask              r_out_mask;
    logic [DigitW-1:0]  n_digit_count;
    logic [LetterW-1:0] n_letter_count;
    logic [LetterW-1:0] n_letters_before;
    t_mask              n_found_mask;
    logic               n_out_valid;
    t_mask              n_out_mask;
    logic               out_free;
    logic               pop;
    logic               last_pop;
    logic               runs_in_range;
    logic               state_idle;

    // Only a last byte needs the output slot; others pass every cycle
    assign out_free     = !r_out_valid || o_out.ready;
    assign o_item_ready = !i_item.last || out_free;
    assign pop          = i_item_valid && o_item_ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.class_bits = r_out_mask;

    always_comb begin
        n_digit_count    = r_digit_count;
        n_letter_count   = r_letter_count;
        n_letters_before = r_letters_before;
        n_found_mask     = r_found_mask;
        n_out_valid      = r_out_valid && !o_out.ready;
        n_out_mask       = r_out_mask;
        if (pop) begin
            if (i_item.in_window) begin
                if (i_item.numeral) begin
                    if (r_digit_count == '0) n_letters_before = r_letter_count;
                    if (r_digit_count < DigitSat) n_digit_count = r_digit_count + 1'b1;
                    if (n_letters_before == PanLetters && n_digit_count == PanDigits) begin
                        n_found_mask[ClsPan] = 1'b1;
                    end
                    if (n_letters_before == IfscLetters && n_digit_count == IfscDigits
                        && i_item.is_zero) begin
                        n_found_mask[ClsIfsc] = 1'b1;
                    end
                    n_letter_count = '0;
                end else begin
                    if (i_item.capital) begin
                        if (r_letter_count < LetterSat) n_letter_count = r_letter_count + 1'b1;
                    end else begin
                        n_letter_count = '0;
                    end
                    if (r_digit_count != '0) begin
                        n_found_mask  = n_found_mask | run_classes(r_digit_count);
                        n_digit_count = '0;
                    end
                end
            end
            if (i_item.last) begin
                // An open digit run is judged at the end of the message
                n_out_valid      = 1'b1;
                n_out_mask       = n_found_mask | run_classes(n_digit_count);
                n_digit_count    = '0;
                n_letter_count   = '0;
                n_letters_before = '0;
                n_found_mask     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count    <= '0;
            r_letter_count   <= '0;
            r_letters_before <= '0;
            r_found_mask     <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_digit_count    <= n_digit_count;
            r_letter_count   <= n_letter_count;
            r_letters_before <= n_letters_before;
            r_found_mask     <= n_found_mask;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_mask <= n_out_mask;
    end

    assign last_pop      = pop && i_item.last;
    assign runs_in_range = (r_digit_count <= DigitSat) && (r_letter_count <= LetterSat);
    assign state_idle    = (r_digit_count == '0) && (r_found_mask == '0);

    `SDCS_ASSERT_ALWAYS(a_runs_saturate, i_clk, i_rst_n, runs_in_range)
    `SDCS_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, last_pop, state_idle && r_out_valid)
    `SDCS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, last_pop, out_free)

endmodule

>>> design/sensitive_data_class_scanner.sv
// Top level of the sensitive data class scanner.
// Depends on sdcs_pkg, sdcs_stream_if, sdcs_front, sdcs_queue and sdcs_back.
`timescale 1ns / 1ps
// Usage:
//   i_in   byte stream: data_byte is one raw ASCII byte, last_byte marks the
//          final byte of a message. An item moves when valid and ready are high.
//   o_out  one class_bits item per message (bit0 PAN, bit1 Aadhaar, bit2 IFSC,
//          bit3 account number, bit4 card), issued for the last byte only.
//   Only the first WINDOW_BYTES (256) bytes of a message are scanned; later
//   bytes are taken but leave the counters alone.
// Throughput: one byte per cycle while i_in.ready is high. The front classifies in
//   the accept cycle, a two-entry queue decouples it from the back, which
//   updates the run counters once per byte.
// Path: the mask of a message goes through the queue and then the output
//   register before it appears on o_out.
// Stall: while o_out is held off, non-final bytes keep draining; a second last
//   byte waits in the queue, and i_in.ready drops once the queue is full.
// Reset: synchronous, active low; clears counters, queue and output valid.
module sensitive_data_class_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdcs_in_if.sink     i_in,
    sdcs_out_if.source  o_out
);
    import sdcs_pkg::*;

    t_item front_item;
    logic  front_valid;
    logic  front_ready;
    t_item back_item;
    logic  back_valid;
    logic  back_ready;

    // Classifier and window position
    sdcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready)
    );

    // Decoupling queue
    sdcs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_item  (front_item),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_pop_item   (back_item),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready)
    );

    // Run counters, detection and output register
    sdcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (back_item),
        .i_item_valid (back_valid),
        .o_item_ready (back_ready),
        .o_out        (o_out)
    );

endmodule

>>> verif/sdcs_scan_checker.sv
// Scoreboard for the sensitive data class scanner: watches both streams,
// predicts the class mask of every message and compares it on delivery.
// Depends on sdcs_pkg and sdcs_stream_if.
`timescale 1ns / 1ps

module sdcs_scan_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sdcs_in_if   i_bytes,
    sdcs_out_if  i_masks,
    output int   o_fail_count,
    output int   o_pending
);
    import sdcs_pkg::*;

    // Scan state of the message in flight
    logic [PosW-1:0]    win_pos;
    logic [DigitW-1:0]  digit_len;
    logic [LetterW-1:0] upper_run;
    logic [LetterW-1:0] upper_at_run;
    t_mask              seen_mask;

    // Masks of finished messages not yet delivered, oldest first
    t_mask pending_masks[$];
    int    fails = 0;

    function automatic t_mask run_length_classes(input logic [DigitW-1:0] len);
        t_mask m;
        m = '0;
        m[ClsAadhaar] = (len == AadhaarLen);
        m[ClsCard]    = (len >= CardMinLen);
        m[ClsAccount] = (len >= AcctMinLen) && (len <= AcctMaxLen);
        return m;
    endfunction

    task clear_message();
        win_pos      = '0;
        digit_len    = '0;
        upper_run    = '0;
        upper_at_run = '0;
        seen_mask    = '0;
    endtask

    task scan_one_byte(input logic [ByteW-1:0] b);
        if (b >= AsciiZero && b <= AsciiNine) begin
            if (digit_len == '0) upper_at_run = upper_run;
            if (digit_len < DigitSat) digit_len = digit_len + 1'b1;
            if (upper_at_run == PanLetters && digit_len == PanDigits)
                seen_mask[ClsPan] = 1'b1;
            if (upper_at_run == IfscLetters && digit_len == IfscDigits && b == AsciiZero)
                seen_mask[ClsIfsc] = 1'b1;
            upper_run = '0;
        end else begin
            if (b >= AsciiUpA && b <= AsciiUpZ) begin
                if (upper_run < LetterSat) upper_run = upper_run + 1'b1;
            end else begin
                upper_run = '0;
            end
            if (digit_len != '0) begin
                seen_mask = seen_mask | run_length_classes(digit_len);
                digit_len = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_mask want;
        if (!i_rst_n) begin
            clear_message();
            pending_masks.delete();
        end else begin
            // delivery first: a mask never leaves in the cycle its last byte enters
            if (i_masks.valid && i_masks.ready) begin
                if (pending_masks.size() == 0) begin
                    $error("class_bits: expected none, actual %b", i_masks.class_bits);
                    fails++;
                end else begin
                    want = pending_masks.pop_front();
                    if (i_masks.class_bits !== want) begin
                        $error("class_bits: expected %b, actual %b", want, i_masks.class_bits);
                        fails++;
                    end
                end
            end
            if (i_bytes.valid && i_bytes.ready) begin
                if (win_pos < PosW'(WindowBytes)) begin
                    scan_one_byte(i_bytes.data_byte);
                    win_pos = win_pos + 1'b1;
                end
                if (i_bytes.last_byte) begin
                    // a digit run still open at the end is judged like a closed one
                    pending_masks.push_back(seen_mask | run_length_classes(digit_len));
                    clear_message();
                end
            end
        end
        o_pending    <= pending_masks.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/sensitive_data_class_scanner_tb.sv
// Testbench top for the sensitive data class scanner: clock, reset, message
// stimulus, output back-pressure and the verdict.
// Depends on sdcs_pkg, sdcs_stream_if, the scanner RTL and sdcs_scan_checker.
`timescale 1ns / 1ps

module sensitive_data_class_scanner_tb;
    import sdcs_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int LongHold   = 160;   // receiver hold-off, long enough to back up the input
    localparam int TailCycles = 10;    // idle tail after the last mask is delivered

    // Building blocks of random messages. PAN and IFSC shapes include near
    // misses (one letter or digit short or long) so the exact counts matter.
    typedef enum int {
        FR_PAN,
        FR_IFSC,
        FR_DIGITS,
        FR_UPPER,
        FR_LOWER,
        FR_SEP,
        FR_HIGH,
        FR_NOISE
    } t_frag;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles     = 0;
    int   rand_bytes = 0;
    int   msgs;
    bit   idle_on    = 1'b1;
    bit   hold_req   = 1'b0;

    logic [ByteW-1:0] msg_bytes[$];

    sdcs_in_if  byte_ch();
    sdcs_out_if mask_ch();

    sensitive_data_class_scanner uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (mask_ch)
    );

    sdcs_scan_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_bytes      (byte_ch),
        .i_masks      (mask_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("sensitive_data_class_scanner_tb failed");
            $finish;
        end
    end

    // Mask receiver. Random stall bursts while idle_on is set; a hold request
    // keeps ready low long enough for the two-entry queue to fill and the
    // scanner to drop its input ready.
    initial begin
        mask_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                mask_ch.ready <= 1'b0;
                repeat (LongHold) @(negedge clk);
                hold_req = 1'b0;
                mask_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                mask_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end else begin
                mask_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [ByteW-1:0] rand_digit();
        return AsciiZero + ByteW'($urandom_range(0, 9));
    endfunction

    function automatic logic [ByteW-1:0] rand_upper();
        return AsciiUpA + ByteW'($urandom_range(0, 25));
    endfunction

    // Separators, weighted toward the neighbors of the digit and letter ranges.
    function automatic logic [ByteW-1:0] sep_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h2F;
            2:       return 8'h3A;
            3:       return 8'h40;
            4:       return 8'h5B;
            default: return 8'h60;
        endcase
    endfunction

    function automatic void add_fragment();
        t_frag kind;
        int    n;
        kind = t_frag'($urandom_range(0, int'(FR_NOISE)));
        case (kind)
            FR_PAN: begin
                if ($urandom_range(0, 1)) msg_bytes.push_back(sep_byte());
                n = $urandom_range(0, 1) ? 5 : $urandom_range(4, 6);
                repeat (n) msg_bytes.push_back(rand_upper());
                n = $urandom_range(0, 1) ? 4 : $urandom_range(3, 5);
                repeat (n) msg_bytes.push_back(rand_digit());
                if ($urandom_range(0, 1)) msg_bytes.push_back(rand_upper());
            end
            FR_IFSC: begin
                if ($urandom_range(0, 1)) msg_bytes.push_back(sep_byte());
                n = $urandom_range(0, 1) ? 4 : $urandom_range(3, 5);
                repeat (n) msg_bytes.push_back(rand_upper());
                msg_bytes.push_back($urandom_range(0, 3) != 0 ? AsciiZero : rand_digit());
                repeat ($urandom_range(0, 7)) msg_bytes.push_back(rand_digit());
            end
            FR_DIGITS: begin
                // mostly around the 9..18 / 12 / 13+ boundaries and saturation
                n = $urandom_range(0, 1) ? $urandom_range(8, 22) : $urandom_range(1, 22);
                repeat (n) msg_bytes.push_back(rand_digit());
            end
            FR_UPPER: repeat ($urandom_range(1, 10)) msg_bytes.push_back(rand_upper());
            FR_LOWER: repeat ($urandom_range(1, 4))
                msg_bytes.push_back(ByteW'($urandom_range(8'h61, 8'h7A)));
            FR_SEP:   msg_bytes.push_back(sep_byte());
            FR_HIGH:  repeat ($urandom_range(1, 3))
                msg_bytes.push_back(ByteW'($urandom_range(128, 255)));
            default:  repeat ($urandom_range(1, 4))
                msg_bytes.push_back(ByteW'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic void build_message(input int target);
        msg_bytes.delete();
        while (msg_bytes.size() < target) add_fragment();
    endfunction

    // Offer one byte and wait for it to be taken. Called at a falling edge,
    // returns at a falling edge; valid stays high between back-to-back items.
    task automatic push_byte(input logic [ByteW-1:0] b, input bit is_last);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        @(posedge clk);
        while (byte_ch.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task automatic send_text(input string s);
        msg_bytes.delete();
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
        send_message();
    endtask

    // Stop offering and let every outstanding mask come out.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (TailCycles) @(negedge clk);
    endtask

    initial begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: PAN with its four digits still open at the last byte,
        // IFSC ending on its '0', the byte extremes (0xFF is above 127),
        // a lone digit, and the 12-digit Aadhaar run closed by a letter.
        send_text("ABCDE1234");
        send_text("ABCD0");
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        send_text("7");
        send_text("123456789012Z");
        drain();

        // Random messages. One runs past the 256-byte window; one starts a long
        // receiver hold-off; one drains fully before going on; the tail of the
        // run goes without any idling.
        msgs = 0;
        while (rand_bytes < 800 || msgs < 30) begin
            if (msgs == 12)
                build_message($urandom_range(270, 330));
            else
                build_message($urandom_range(1, 24));
            if (msgs == 20) hold_req = 1'b1;
            if (rand_bytes >= 650) idle_on = 1'b0;
            send_message();
            rand_bytes += msg_bytes.size();
            msgs++;
            if (msgs == 28) drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("sensitive_data_class_scanner_tb passed");
        end else begin
            $display("sensitive_data_class_scanner_tb failed");
        end
        $finish;
    end

endmodule
